/* src/sls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_pkg
// Shared widths, command codes and status codes of the sequential list store.
// ----------------------------------------------------------------------------
package sls_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_APPEND = 3'd0;
    localparam cmd_t CMD_DELETE = 3'd1;
    localparam cmd_t CMD_READ   = 3'd2;
    localparam cmd_t CMD_FIND   = 3'd3;
    localparam cmd_t CMD_DUMP   = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

endpackage

/* src/sls_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sls_ifs
// Command and result channels of the sequential list store (valid/ready).
// ----------------------------------------------------------------------------
interface sls_req_if
    import sls_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [POS_W-1:0]    position;
    logic [BYTE_W-1:0]   content;

    modport source (output valid, output command, output position, output content,
                    input ready);
    modport sink   (input valid, input command, input position, input content,
                    output ready);
endinterface

interface sls_rsp_if
    import sls_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [BYTE_W-1:0]   entry_value;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;

    modport source (output valid, output status, output found_position,
                    output entry_value, output entry_count, output last,
                    input ready);
    modport sink   (input valid, input status, input found_position,
                    input entry_value, input entry_count, input last,
                    output ready);
endinterface

/* src/sequential_list_store_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequential_list_store_unit
// Ordered byte list kept in a single-port-write / single-port-read memory.
// ----------------------------------------------------------------------------
// One command is taken at a time; req.ready is high only while the unit is
// idle. All work goes through one synchronous memory (one write and one read
// per cycle, registered read data), so the time per command is set by the
// number of memory accesses: delete at position p moves each later entry
// with one read and one write, and find ends with a closing step that
// sends the held last match. Each result occupies the output register until
// taken; a stalled result channel stalls the walk. No clearing pass runs
// after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sequential_list_store_unit
    import sls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    sls_req_if.sink    req,
    sls_rsp_if.source  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD_DATA,
        S_DEL_HEAD,
        S_DEL_STEP,
        S_DEL_MOVE,
        S_SCAN,
        S_SCAN_END
    } state_t;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    state_t              state_reg,     state_next;
    logic [CW-1:0]       count_reg,     count_next;
    logic [AW-1:0]       idx_reg,       idx_next;
    cmd_t                cmd_reg,       cmd_next;
    logic [POS_W-1:0]    pos_reg,       pos_next;
    logic [BYTE_W-1:0]   content_reg,   content_next;
    logic                pend_vld_reg,  pend_vld_next;
    logic [POS_W-1:0]    pend_pos_reg,  pend_pos_next;
    logic [BYTE_W-1:0]   pend_val_reg,  pend_val_next;
    logic                out_vld_reg,   out_vld_next;
    status_t             out_st_reg,    out_st_next;
    logic [POS_W-1:0]    out_pos_reg,   out_pos_next;
    logic [BYTE_W-1:0]   out_val_reg,   out_val_next;
    logic [COUNT_W-1:0]  out_cnt_reg,   out_cnt_next;
    logic                out_last_reg,  out_last_next;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;

    logic              can_emit;
    logic              emit;
    logic              fail;
    status_t           fail_st;
    status_t           res_st;
    logic [POS_W-1:0]  res_pos;
    logic [BYTE_W-1:0] res_val;
    logic              res_last;

    logic [MW-1:0]     pos_ext;
    logic [MW-1:0]     cnt_ext;
    logic [MW-1:0]     pos_m1;
    logic              pos_ok;
    logic [AW:0]       idx_p1;
    logic              more;
    logic              full;
    logic              hit;
    logic              go;
    logic              is_dump;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        pos_ext  = MW'(pos_reg);
        cnt_ext  = MW'(count_reg);
        pos_m1   = pos_ext - MW'(1);
        pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
        idx_p1   = {1'b0, idx_reg} + (AW+1)'(1);
        more     = idx_p1 < (AW+1)'(count_reg);
        full     = count_reg == CW'(DEPTH);
        is_dump  = cmd_reg == CMD_DUMP;
        hit      = is_dump || (rd_data_reg == content_reg);
        can_emit = !out_vld_reg || rsp.ready;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        content_next  = content_reg;
        pend_vld_next = pend_vld_reg;
        pend_pos_next = pend_pos_reg;
        pend_val_next = pend_val_reg;

        rd_en    = 1'b0;
        rd_addr  = idx_reg;
        wr_en    = 1'b0;
        wr_addr  = idx_reg;
        wr_data  = rd_data_reg;

        emit     = 1'b0;
        fail     = 1'b0;
        fail_st  = ST_NOT_FOUND;
        go       = 1'b0;
        res_st   = ST_OK;
        res_pos  = '0;
        res_val  = '0;
        res_last = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.command;
                    pos_next     = req.position;
                    content_next = req.content;
                    state_next   = S_START;
                end
            end

            S_START:
            begin
                case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (full)
                        begin
                            fail    = 1'b1;
                            fail_st = ST_FULL;
                        end
                        else if (can_emit)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = content_reg;
                            count_next = count_reg + CW'(1);
                            emit       = 1'b1;
                            res_pos    = POS_W'(count_next);
                            res_val    = content_reg;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            fail    = 1'b1;
                            fail_st = ST_EMPTY;
                        end
                        else if (!pos_ok)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_m1[AW-1:0];
                            idx_next   = pos_m1[AW-1:0];
                            state_next = S_DEL_HEAD;
                        end
                    end
                    CMD_READ:
                    begin
                        if (!pos_ok)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = pos_m1[AW-1:0];
                            state_next = S_RD_DATA;
                        end
                    end
                    CMD_FIND, CMD_DUMP:
                    begin
                        if (count_reg == '0)
                        begin
                            fail    = 1'b1;
                            fail_st = is_dump ? ST_EMPTY : ST_NOT_FOUND;
                        end
                        else
                        begin
                            rd_en         = 1'b1;
                            rd_addr       = '0;
                            idx_next      = '0;
                            pend_vld_next = 1'b0;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        fail = 1'b1;
                    end
                endcase

                if (fail && can_emit)
                begin
                    emit       = 1'b1;
                    res_st     = fail_st;
                    state_next = S_IDLE;
                end
            end

            S_RD_DATA:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    res_pos    = pos_reg;
                    res_val    = rd_data_reg;
                    state_next = S_IDLE;
                end
            end

            S_DEL_HEAD:
            begin
                // hold the removed byte until the gap is closed
                pend_val_next = rd_data_reg;
                state_next    = S_DEL_STEP;
            end

            S_DEL_STEP:
            begin
                if (more)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_p1[AW-1:0];
                    state_next = S_DEL_MOVE;
                end
                else if (can_emit)
                begin
                    count_next = count_reg - CW'(1);
                    emit       = 1'b1;
                    res_pos    = pos_reg;
                    res_val    = pend_val_reg;
                    state_next = S_IDLE;
                end
            end

            S_DEL_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data_reg;
                idx_next   = idx_p1[AW-1:0];
                state_next = S_DEL_STEP;
            end

            S_SCAN:
            begin
                // find keeps the latest match back so its last flag is known
                if (is_dump)
                begin
                    go = can_emit;
                    if (can_emit)
                    begin
                        emit     = 1'b1;
                        res_pos  = POS_W'(idx_p1);
                        res_val  = rd_data_reg;
                        res_last = !more;
                    end
                end
                else
                begin
                    go = !(hit && pend_vld_reg) || can_emit;
                    if (hit && go)
                    begin
                        if (pend_vld_reg)
                        begin
                            emit     = 1'b1;
                            res_pos  = pend_pos_reg;
                            res_val  = pend_val_reg;
                            res_last = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_pos_next = POS_W'(idx_p1);
                        pend_val_next = rd_data_reg;
                    end
                end

                if (go)
                begin
                    if (more)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_p1[AW-1:0];
                        idx_next = idx_p1[AW-1:0];
                    end
                    else
                    begin
                        state_next = is_dump ? S_IDLE : S_SCAN_END;
                    end
                end
            end

            S_SCAN_END:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (pend_vld_reg)
                    begin
                        res_pos = pend_pos_reg;
                        res_val = pend_val_reg;
                    end
                    else
                    begin
                        res_st = ST_NOT_FOUND;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next  = out_vld_reg && !rsp.ready;
        out_st_next   = out_st_reg;
        out_pos_next  = out_pos_reg;
        out_val_next  = out_val_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        if (emit)
        begin
            out_vld_next  = 1'b1;
            out_st_next   = res_st;
            out_pos_next  = res_pos;
            out_val_next  = res_val;
            out_cnt_next  = COUNT_W'(count_next);
            out_last_next = res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            cmd_reg      <= CMD_APPEND;
            pos_reg      <= '0;
            content_reg  <= '0;
            pend_vld_reg <= 1'b0;
            pend_pos_reg <= '0;
            pend_val_reg <= '0;
            out_vld_reg  <= 1'b0;
            out_st_reg   <= ST_OK;
            out_pos_reg  <= '0;
            out_val_reg  <= '0;
            out_cnt_reg  <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            cmd_reg      <= cmd_next;
            pos_reg      <= pos_next;
            content_reg  <= content_next;
            pend_vld_reg <= pend_vld_next;
            pend_pos_reg <= pend_pos_next;
            pend_val_reg <= pend_val_next;
            out_vld_reg  <= out_vld_next;
            out_st_reg   <= out_st_next;
            out_pos_reg  <= out_pos_next;
            out_val_reg  <= out_val_next;
            out_cnt_reg  <= out_cnt_next;
            out_last_reg <= out_last_next;
        end
    end

    assign req.ready          = state_reg == S_IDLE;
    assign rsp.valid          = out_vld_reg;
    assign rsp.status         = out_st_reg;
    assign rsp.found_position = out_pos_reg;
    assign rsp.entry_value    = out_val_reg;
    assign rsp.entry_count    = out_cnt_reg;
    assign rsp.last           = out_last_reg;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sequential_list_store_unit. A directed table covers
// the empty list, the field extremes, every command and the empty and not-found
// statuses. A long random part follows: it grows the list, fills it to capacity,
// shrinks it, and packs in duplicate bytes so finds return long match runs.
// An in-bench list model predicts the results the table does not give. Each
// result transfer is compared field by field with the oldest prediction. Both
// channels idle at random, and the result side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import sls_pkg::*;

    localparam int   LIST_DEPTH      = DEPTH_DEFAULT;
    localparam int   POS_MAX_CODE    = (1 << POS_W) - 1;
    localparam int   IDLE_PCT        = 34;
    localparam int   RAND_ITEMS      = 180;
    localparam int   HOLD_OFF_CYCLES = 300;
    localparam int   SETTLE_CYCLES   = 2 * LIST_DEPTH + 20;
    localparam int   CYCLE_LIMIT     = 600000;

    // command codes with no function in the unit
    localparam cmd_t CMD_RSVD_LO  = 3'd5;
    localparam cmd_t CMD_RSVD_MID = 3'd6;
    localparam cmd_t CMD_RSVD_HI  = 3'd7;

    localparam bit   TYPED    = 1'b1;
    localparam bit   NO_CHECK = 1'b0;

    typedef struct packed {
        status_t             status;
        logic [POS_W-1:0]    found_position;
        logic [BYTE_W-1:0]   entry_value;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } list_rsp_t;

    typedef struct packed {
        cmd_t                command;
        logic [POS_W-1:0]    position;
        logic [BYTE_W-1:0]   content;
        bit                  typed;
        list_rsp_t           want;
    } stim_row_t;

    typedef enum int {MODE_DENSE, MODE_GROW, MODE_SHRINK} stim_mode_t;

    logic clk;
    logic rst_n;

    sls_req_if cmd_ch ();
    sls_rsp_if res_ch ();

    sequential_list_store_unit #(
        .DEPTH (LIST_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cmd_ch),
        .rsp   (res_ch)
    );

    // list model
    logic [BYTE_W-1:0] list_bytes [LIST_DEPTH] = '{default: '0};
    int                list_len = 0;
    list_rsp_t         expected_rsp [$];

    int        errors = 0;
    int        cycle_count = 0;
    bit        steady_win;
    bit        hold_toggle;
    bit        row_typed;
    list_rsp_t row_want;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic list_rsp_t mk_rsp(status_t st, int fpos, int val);
        list_rsp_t r;
        r.status         = st;
        r.found_position = POS_W'(fpos);
        r.entry_value    = BYTE_W'(val);
        r.entry_count    = COUNT_W'(list_len);
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t mk_row(cmd_t c, int p, int b, bit typed,
                                         status_t st, int fpos, int val, int cnt);
        stim_row_t row;
        row.command             = c;
        row.position            = POS_W'(p);
        row.content             = BYTE_W'(b);
        row.typed               = typed;
        row.want.status         = st;
        row.want.found_position = POS_W'(fpos);
        row.want.entry_value    = BYTE_W'(val);
        row.want.entry_count    = COUNT_W'(cnt);
        row.want.last           = 1'b1;
        return row;
    endfunction

    // Applies one accepted command to the model and queues what it must emit.
    task automatic model_command(input cmd_t c, input logic [POS_W-1:0] p,
                                 input logic [BYTE_W-1:0] b, input bit typed,
                                 input list_rsp_t want);
        list_rsp_t         fresh [$];
        logic [BYTE_W-1:0] gone;
        int                i;
        case (c)
            CMD_APPEND:
                if (list_len >= LIST_DEPTH)
                    fresh.push_back(mk_rsp(ST_FULL, 0, 0));
                else
                begin
                    list_bytes[list_len] = b;
                    list_len++;
                    fresh.push_back(mk_rsp(ST_OK, list_len, b));
                end
            CMD_DELETE:
                if (list_len == 0)
                    fresh.push_back(mk_rsp(ST_EMPTY, 0, 0));
                else if (p == 0 || p > list_len)
                    fresh.push_back(mk_rsp(ST_NOT_FOUND, 0, 0));
                else
                begin
                    gone = list_bytes[p-1];
                    for (i = p - 1; i + 1 < list_len; i++)
                        list_bytes[i] = list_bytes[i+1];
                    list_len--;
                    fresh.push_back(mk_rsp(ST_OK, p, gone));
                end
            CMD_READ:
                if (p == 0 || p > list_len)
                    fresh.push_back(mk_rsp(ST_NOT_FOUND, 0, 0));
                else
                    fresh.push_back(mk_rsp(ST_OK, p, list_bytes[p-1]));
            CMD_FIND:
            begin
                for (i = 0; i < list_len; i++)
                    if (list_bytes[i] == b)
                        fresh.push_back(mk_rsp(ST_OK, i + 1, b));
                if (fresh.size() == 0)
                    fresh.push_back(mk_rsp(ST_NOT_FOUND, 0, 0));
            end
            CMD_DUMP:
                if (list_len == 0)
                    fresh.push_back(mk_rsp(ST_EMPTY, 0, 0));
                else
                    for (i = 0; i < list_len; i++)
                        fresh.push_back(mk_rsp(ST_OK, i + 1, list_bytes[i]));
            default:
                fresh.push_back(mk_rsp(ST_NOT_FOUND, 0, 0));
        endcase
        fresh[fresh.size()-1].last = 1'b1;
        if (typed)
            expected_rsp.push_back(want);
        else
            foreach (fresh[j])
                expected_rsp.push_back(fresh[j]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Results are checked before the same edge's command is modeled: a result
    // can never belong to a command accepted at that very edge.
    always @(posedge clk)
    begin
        list_rsp_t want;
        if (rst_n === 1'b1)
        begin
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual status %0d pos %0d",
                             $time, res_ch.status, res_ch.found_position);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("status", 32'(want.status), 32'(res_ch.status));
                    check_field("found_position", 32'(want.found_position),
                                32'(res_ch.found_position));
                    check_field("entry_value", 32'(want.entry_value),
                                32'(res_ch.entry_value));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(res_ch.entry_count));
                    check_field("last", 32'(want.last), 32'(res_ch.last));
                end
            end
            if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1)
                model_command(cmd_ch.command, cmd_ch.position, cmd_ch.content,
                              row_typed, row_want);
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        bit hold_seen;
        hold_seen    = 1'b0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            res_ch.ready <= steady_win || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic offer(input stim_row_t row);
        if (!steady_win)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                cmd_ch.valid <= 1'b0;
                @(posedge clk);
            end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= row.command;
        cmd_ch.position <= row.position;
        cmd_ch.content  <= row.content;
        row_typed       <= row.typed;
        row_want        <= row.want;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (list_len > 0 && r < 80)
            return POS_W'($urandom_range(list_len, 1));
        if (r < 90)
            return '0;
        return POS_W'($urandom_range(POS_MAX_CODE, 0));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_search_byte();
        if (list_len > 0 && $urandom_range(99) < 70)
            return list_bytes[$urandom_range(list_len - 1, 0)];
        return BYTE_W'($urandom_range(255, 0));
    endfunction

    function automatic logic [BYTE_W-1:0] dense_byte();
        case ($urandom_range(2))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'hA5;
        endcase
    endfunction

    function automatic stim_row_t random_row(stim_mode_t mode);
        stim_row_t row;
        int        r;
        r   = $urandom_range(99);
        row = mk_row(CMD_APPEND, pick_position(), $urandom_range(255, 0), NO_CHECK,
                     ST_OK, 0, 0, 0);
        case (mode)
            MODE_DENSE:
            begin
                row.content = dense_byte();
                if (r < 55)      row.command = CMD_APPEND;
                else if (r < 80) row.command = CMD_FIND;
                else if (r < 88) row.command = CMD_READ;
                else if (r < 94) row.command = CMD_DELETE;
                else             row.command = CMD_DUMP;
            end
            MODE_GROW:
            begin
                if (r < 50)      row.command = CMD_APPEND;
                else if (r < 65) row.command = CMD_READ;
                else if (r < 75) row.command = CMD_FIND;
                else if (r < 85) row.command = CMD_DELETE;
                else if (r < 90) row.command = CMD_DUMP;
                else             row.command = cmd_t'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
            end
            default:
            begin
                if (r < 50)      row.command = CMD_DELETE;
                else if (r < 62) row.command = CMD_APPEND;
                else if (r < 75) row.command = CMD_READ;
                else if (r < 85) row.command = CMD_FIND;
                else if (r < 92) row.command = CMD_DUMP;
                else             row.command = cmd_t'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
            end
        endcase
        if (row.command == CMD_FIND && mode != MODE_DENSE)
            row.content = pick_search_byte();
        return row;
    endfunction

    initial
    begin : stimulus
        stim_row_t  directed [$];
        stim_mode_t mode;
        int         k;
        int         extra;

        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = CMD_APPEND;
        cmd_ch.position = '0;
        cmd_ch.content  = '0;
        row_typed       = 1'b0;
        row_want        = '0;
        steady_win      = 1'b0;
        hold_toggle     = 1'b0;

        // empty list after reset
        directed.push_back(mk_row(CMD_DUMP,   0, 0, TYPED, ST_EMPTY, 0, 0, 0));
        directed.push_back(mk_row(CMD_DELETE, 1, 0, TYPED, ST_EMPTY, 0, 0, 0));
        directed.push_back(mk_row(CMD_READ,   1, 0, TYPED, ST_NOT_FOUND, 0, 0, 0));
        directed.push_back(mk_row(CMD_FIND,   0, 8'h00, TYPED, ST_NOT_FOUND, 0, 0, 0));
        // byte extremes
        directed.push_back(mk_row(CMD_APPEND, 0, 8'h00, TYPED, ST_OK, 1, 8'h00, 1));
        directed.push_back(mk_row(CMD_APPEND, 0, 8'hFF, TYPED, ST_OK, 2, 8'hFF, 2));
        directed.push_back(mk_row(CMD_APPEND, 0, 8'h5A, TYPED, ST_OK, 3, 8'h5A, 3));
        directed.push_back(mk_row(CMD_APPEND, 0, 8'hFF, TYPED, ST_OK, 4, 8'hFF, 4));
        // positions zero, one past the count and all ones
        directed.push_back(mk_row(CMD_READ, 0, 0, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_READ, 5, 0, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_READ, POS_MAX_CODE, 8'hFF, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_READ, 1, 0, TYPED, ST_OK, 1, 8'h00, 4));
        directed.push_back(mk_row(CMD_READ, 4, 0, TYPED, ST_OK, 4, 8'hFF, 4));
        // two matches, then no match
        directed.push_back(mk_row(CMD_FIND, 0, 8'hFF, NO_CHECK, ST_OK, 0, 0, 0));
        directed.push_back(mk_row(CMD_FIND, 0, 8'h11, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_DUMP, 0, 0, NO_CHECK, ST_OK, 0, 0, 0));
        // undefined command codes
        directed.push_back(mk_row(CMD_RSVD_LO,  0, 0, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_RSVD_MID, 1, 8'hFF, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_RSVD_HI,  POS_MAX_CODE, 0, TYPED, ST_NOT_FOUND, 0, 0, 4));
        // deletes: bad positions, middle, tail, head
        directed.push_back(mk_row(CMD_DELETE, 0, 0, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_DELETE, 5, 0, TYPED, ST_NOT_FOUND, 0, 0, 4));
        directed.push_back(mk_row(CMD_DELETE, 2, 0, TYPED, ST_OK, 2, 8'hFF, 3));
        directed.push_back(mk_row(CMD_DELETE, 3, 0, TYPED, ST_OK, 3, 8'hFF, 2));
        directed.push_back(mk_row(CMD_DELETE, 1, 0, TYPED, ST_OK, 1, 8'h00, 1));
        directed.push_back(mk_row(CMD_DUMP, 0, 0, NO_CHECK, ST_OK, 0, 0, 0));

        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (directed[i])
            offer(directed[i]);
        drain();

        for (k = 0; k < RAND_ITEMS; k++)
        begin
            if (k == 40)
            begin
                // fill to capacity, then two appends that must report full
                while (list_len < LIST_DEPTH)
                    offer(mk_row(CMD_APPEND, 0, $urandom_range(255, 0), NO_CHECK,
                                 ST_OK, 0, 0, 0));
                for (extra = 0; extra < 2; extra++)
                    offer(mk_row(CMD_APPEND, pick_position(), $urandom_range(255, 0),
                                 NO_CHECK, ST_OK, 0, 0, 0));
                offer(mk_row(CMD_DUMP, 0, 0, NO_CHECK, ST_OK, 0, 0, 0));
            end
            if (k == 100)
            begin
                // result side blocks while commands keep coming
                hold_toggle <= ~hold_toggle;
                offer(mk_row(CMD_DUMP, 0, 0, NO_CHECK, ST_OK, 0, 0, 0));
            end
            if (k == 130 || k == 160)
                drain();
            steady_win <= (k >= 130 && k < 160);

            if (k < 40)       mode = MODE_DENSE;
            else if (k < 80)  mode = MODE_SHRINK;
            else if (k < 110) mode = MODE_GROW;
            else if (k < 150) mode = (k % 20 < 10) ? MODE_SHRINK : MODE_DENSE;
            else              mode = MODE_GROW;
            offer(random_row(mode));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && expected_rsp.size() == 0)
            $display("testbench: PASS");
        else
        begin
            if (expected_rsp.size() != 0)
                $display("%0t: %0d results never arrived", $time, expected_rsp.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
